[rtl/a_star_shortest_path_defines.svh]
// Assertion macros shared by the A* search block.
`ifndef A_STAR_SHORTEST_PATH_DEFINES_SVH
`define A_STAR_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define ASTAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define ASTAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/astar_pkg.sv]
// Types, constants and helper functions of the A* search block.
package astar_pkg;

  localparam int IDX_W    = 6;
  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int FRAC_W   = 8;
  localparam int CNT_W    = 7;

  localparam logic [COST_W-1:0] COST_INF = '1;

  localparam logic [1:0] CMD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam int RAD_W      = 50;
  localparam int ROOT_W     = 25;
  localparam int REM_W      = 27;
  localparam int SQRT_STEPS = 25;

  typedef struct packed {
    logic               go;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
  } astar_hreq_t;

  typedef struct packed {
    logic              done;
    logic [COST_W-1:0] value;
  } astar_hrsp_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_INF : s[COST_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

[rtl/astar_hsqrt.sv]
// Euclidean heuristic unit: squares, sum, then bit-serial integer square root.
module astar_hsqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  astar_pkg::astar_hreq_t  hreq,
  output astar_pkg::astar_hrsp_t  hrsp
);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_SUM, H_ROOT} state_t;

  state_t                                state_r;
  logic [astar_pkg::COORD_W-1:0]         ax_r;
  logic [astar_pkg::COORD_W-1:0]         ay_r;
  logic [2*astar_pkg::COORD_W-1:0]       sqx_r;
  logic [2*astar_pkg::COORD_W-1:0]       sqy_r;
  logic [astar_pkg::RAD_W-1:0]           rad_r;
  logic [astar_pkg::ROOT_W-1:0]          root_r;
  logic [astar_pkg::REM_W-1:0]           rem_r;
  logic [4:0]                            step_r;
  logic                                  done_r;

  logic [astar_pkg::REM_W+1:0]           rem_t;
  logic [astar_pkg::REM_W+1:0]           trial;
  logic [astar_pkg::REM_W+1:0]           diff;
  logic                                  ge;
  logic [2*astar_pkg::COORD_W:0]         sq_sum;

  assign rem_t  = {rem_r, rad_r[astar_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_t >= trial);
  assign diff   = rem_t - trial;
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (hreq.go) begin
            ax_r    <= hreq.ax;
            ay_r    <= hreq.ay;
            state_r <= H_MUL;
          end
        end
        H_MUL: begin
          sqx_r   <= ax_r * ax_r;
          sqy_r   <= ay_r * ay_r;
          state_r <= H_SUM;
        end
        H_SUM: begin
          rad_r   <= {sq_sum, 16'b0};
          root_r  <= '0;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= H_ROOT;
        end
        H_ROOT: begin
          rad_r  <= {rad_r[astar_pkg::RAD_W-3:0], 2'b00};
          rem_r  <= ge ? diff[astar_pkg::REM_W-1:0] : rem_t[astar_pkg::REM_W-1:0];
          root_r <= {root_r[astar_pkg::ROOT_W-2:0], ge};
          step_r <= step_r + 5'd1;
          if (step_r == 5'(astar_pkg::SQRT_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign hrsp.done  = done_r;
  assign hrsp.value = astar_pkg::COST_W'(root_r);

endmodule

[rtl/a_star_shortest_path.sv]
// A* shortest path search: graph memories, search sequencer and result port.
//
// Usage: load coordinates (cmd 0) and directed edge weights (cmd 1) through
// the in_ channel, one item per cycle while in_ready is high; each load item
// gives no result. A search item (cmd 2) runs A* from start to goal and sends
// the path, start first, one item per vertex on the out_ channel with last set
// on the final one, or one item with found clear if no path exists or start or
// goal is out of range. in_ready is low for the whole search and until the
// last result is taken. A search first prepares the per-vertex tables and
// computes the start heuristic; each expansion then scans the open list for
// the minimum, moves the entries behind the chosen one when it is dropped,
// and sweeps all vertices as neighbors, using the shared square-root unit for
// each improved neighbor. The path walk then follows came-from links back from
// the goal, and each result is then sent in turn.
// A receiver that stalls holds the result in the output register and the
// sequencer waits. Reset sets vertex_count to 64 and empties the port;
// graph memories keep no defined value until written.
`include "a_star_shortest_path_defines.svh"
module a_star_shortest_path #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_vertex_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic [5:0]         in_edge_from,
  input  logic [5:0]         in_edge_to,
  input  logic [15:0]        in_edge_weight,
  input  logic [5:0]         in_start_vertex,
  input  logic [5:0]         in_goal_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_path_vertex,
  output logic signed [15:0] out_path_x,
  output logic signed [15:0] out_path_y,
  output logic               out_found,
  output logic               out_last
);

  localparam int DEPTH = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int EDEP  = 1 << (2 * AW);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_START_H, S_START_HW,
    S_SEL_INIT, S_SEL_RD, S_SEL_EST, S_SEL_CMP, S_SEL_DONE,
    S_SH_CHK, S_SH_WR,
    S_NB_RD1, S_NB_RD2, S_NB_CALC, S_NB_H, S_NB_HW, S_NB_OPEN,
    S_PW_RD, S_PW_CHK, S_EM_RD1, S_EM_RD2, S_EM_LOAD, S_EM_WAIT, S_NOTFOUND
  } state_t;

  // memories
  logic [15:0] xs_mem   [DEPTH];
  logic [15:0] ys_mem   [DEPTH];
  logic [15:0] ew_mem   [EDEP];
  logic [31:0] cost_mem [DEPTH];
  logic [31:0] est_mem  [DEPTH];
  logic [AW-1:0] came_mem [DEPTH];
  logic [AW-1:0] open_mem [DEPTH];
  logic [AW-1:0] pbuf_mem [DEPTH];

  logic [15:0]   xs_rd_r, ys_rd_r, ew_rd_r;
  logic [31:0]   cost_rd_r, est_rd_r;
  logic [AW-1:0] came_rd_r, open_rd_r, pbuf_rd_r;

  logic          xy_we;
  logic [AW-1:0] xy_waddr, xy_raddr;
  logic [15:0]   x_wdata, y_wdata;
  logic          ew_we;
  logic [2*AW-1:0] ew_waddr, ew_raddr;
  logic [15:0]   ew_wdata;
  logic          cost_we, est_we, came_we, open_we, pbuf_we;
  logic [AW-1:0] cost_waddr, est_waddr, came_waddr, open_waddr, pbuf_waddr;
  logic [AW-1:0] cost_raddr, est_raddr, came_raddr, open_raddr, pbuf_raddr;
  logic [31:0]   cost_wdata, est_wdata;
  logic [AW-1:0] came_wdata, open_wdata, pbuf_wdata;

  // control registers
  state_t         state_r, state_nxt;
  logic [6:0]     vcount_r, vcount_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  osize_r, osize_nxt;
  logic [DEPTH-1:0] closed_r, closed_nxt;
  logic [DEPTH-1:0] inopen_r, inopen_nxt;

  // payload registers
  logic [5:0]     out_vertex_r, out_vertex_nxt;
  logic [15:0]    out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic           out_found_r, out_found_nxt, out_last_r, out_last_nxt;
  logic [AW-1:0]  start_r, start_nxt, goal_r, goal_nxt;
  logic [15:0]    gx_r, gx_nxt, gy_r, gy_nxt;
  logic [CW-1:0]  k_r, k_nxt, pos_r, pos_nxt, v_r, v_nxt;
  logic [CW-1:0]  plen_r, plen_nxt, cnt_r, cnt_nxt;
  logic [31:0]    best_r, best_nxt, ccost_r, ccost_nxt, cand_r, cand_nxt;
  logic [AW-1:0]  curr_r, curr_nxt, ent_r, ent_nxt, pc_r, pc_nxt;

  astar_pkg::astar_hreq_t hreq;
  astar_pkg::astar_hrsp_t hrsp;

  logic [6:0]    n_eff;
  logic [CW-1:0] nc, kp1, vp1, emit_idx;
  logic [31:0]   cand;
  logic          start_ok;

  assign n_eff    = (vcount_r > 7'(DEPTH)) ? 7'(DEPTH) : vcount_r;
  assign nc       = n_eff[CW-1:0];
  assign kp1      = k_r + CW'(1);
  assign vp1      = v_r + CW'(1);
  assign emit_idx = plen_r - CW'(1) - cnt_r;
  assign cand     = astar_pkg::sat_add(ccost_r, {8'b0, ew_rd_r, 8'b0});
  assign start_ok = ({1'b0, in_start_vertex} < n_eff) && ({1'b0, in_goal_vertex} < n_eff);

  astar_hsqrt u_hsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .hreq (hreq),
    .hrsp (hrsp)
  );

  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    out_valid_nxt  = out_valid_r;
    osize_nxt      = osize_r;
    closed_nxt     = closed_r;
    inopen_nxt     = inopen_r;
    out_vertex_nxt = out_vertex_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    start_nxt      = start_r;
    goal_nxt       = goal_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    v_nxt          = v_r;
    plen_nxt       = plen_r;
    cnt_nxt        = cnt_r;
    best_nxt       = best_r;
    ccost_nxt      = ccost_r;
    cand_nxt       = cand_r;
    curr_nxt       = curr_r;
    ent_nxt        = ent_r;
    pc_nxt         = pc_r;

    hreq        = '0;
    xy_we       = 1'b0;
    xy_waddr    = in_vertex_index[AW-1:0];
    x_wdata     = in_coord_x;
    y_wdata     = in_coord_y;
    xy_raddr    = start_r;
    ew_we       = 1'b0;
    ew_waddr    = {in_edge_from[AW-1:0], in_edge_to[AW-1:0]};
    ew_wdata    = in_edge_weight;
    ew_raddr    = {v_r[AW-1:0], curr_r};
    cost_we     = 1'b0;
    cost_waddr  = v_r[AW-1:0];
    cost_wdata  = astar_pkg::COST_INF;
    cost_raddr  = curr_r;
    est_we      = 1'b0;
    est_waddr   = v_r[AW-1:0];
    est_wdata   = astar_pkg::COST_INF;
    est_raddr   = open_rd_r;
    came_we     = 1'b0;
    came_waddr  = v_r[AW-1:0];
    came_wdata  = v_r[AW-1:0];
    came_raddr  = pc_r;
    open_we     = 1'b0;
    open_waddr  = k_r[AW-1:0];
    open_wdata  = open_rd_r;
    open_raddr  = k_r[AW-1:0];
    pbuf_we     = 1'b0;
    pbuf_waddr  = plen_r[AW-1:0];
    pbuf_wdata  = pc_r;
    pbuf_raddr  = emit_idx[AW-1:0];

    if (cfg_wr_en) begin
      vcount_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        xy_raddr = in_goal_vertex[AW-1:0];
        if (in_valid) begin
          case (in_cmd)
            astar_pkg::CMD_VERTEX: begin
              xy_we = ({1'b0, in_vertex_index} < n_eff);
            end
            astar_pkg::CMD_EDGE: begin
              ew_we = ({1'b0, in_edge_from} < n_eff) && ({1'b0, in_edge_to} < n_eff);
            end
            astar_pkg::CMD_SEARCH: begin
              closed_nxt = '0;
              inopen_nxt = '0;
              osize_nxt  = '0;
              start_nxt  = in_start_vertex[AW-1:0];
              goal_nxt   = in_goal_vertex[AW-1:0];
              v_nxt      = '0;
              state_nxt  = start_ok ? S_INIT : S_NOTFOUND;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        if (v_r == '0) begin
          gx_nxt = xs_rd_r;
          gy_nxt = ys_rd_r;
        end
        cost_we = 1'b1;
        est_we  = 1'b1;
        came_we = 1'b1;
        if (vp1 == nc) begin
          state_nxt = S_START_H;
        end else begin
          v_nxt = vp1;
        end
      end
      S_START_H: begin
        hreq.go   = 1'b1;
        hreq.ax   = astar_pkg::abs_diff(xs_rd_r, gx_r);
        hreq.ay   = astar_pkg::abs_diff(ys_rd_r, gy_r);
        state_nxt = S_START_HW;
      end
      S_START_HW: begin
        if (hrsp.done) begin
          est_we      = 1'b1;
          est_waddr   = start_r;
          est_wdata   = hrsp.value;
          cost_we     = 1'b1;
          cost_waddr  = start_r;
          cost_wdata  = '0;
          open_we     = 1'b1;
          open_waddr  = '0;
          open_wdata  = start_r;
          osize_nxt   = CW'(1);
          inopen_nxt[start_r] = 1'b1;
          state_nxt   = S_SEL_INIT;
        end
      end
      S_SEL_INIT: begin
        if (osize_r == '0) begin
          state_nxt = S_NOTFOUND;
        end else begin
          k_nxt     = '0;
          pos_nxt   = '0;
          best_nxt  = astar_pkg::COST_INF;
          state_nxt = S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        state_nxt = S_SEL_EST;
      end
      S_SEL_EST: begin
        ent_nxt   = open_rd_r;
        state_nxt = S_SEL_CMP;
      end
      S_SEL_CMP: begin
        if (est_rd_r <= best_r) begin
          best_nxt = est_rd_r;
          curr_nxt = ent_r;
          pos_nxt  = k_r;
        end
        k_nxt     = kp1;
        state_nxt = (kp1 == osize_r) ? S_SEL_DONE : S_SEL_RD;
      end
      S_SEL_DONE: begin
        closed_nxt[curr_r] = 1'b1;
        inopen_nxt[curr_r] = 1'b0;
        k_nxt     = pos_r;
        state_nxt = S_SH_CHK;
      end
      S_SH_CHK: begin
        ccost_nxt = cost_rd_r;
        if (kp1 < osize_r) begin
          open_raddr = kp1[AW-1:0];
          state_nxt  = S_SH_WR;
        end else begin
          osize_nxt = osize_r - CW'(1);
          if (curr_r == goal_r) begin
            pc_nxt    = goal_r;
            plen_nxt  = '0;
            state_nxt = S_PW_RD;
          end else begin
            v_nxt     = '0;
            state_nxt = S_NB_RD1;
          end
        end
      end
      S_SH_WR: begin
        open_we   = 1'b1;
        k_nxt     = kp1;
        state_nxt = S_SH_CHK;
      end
      S_NB_RD1: begin
        state_nxt = S_NB_RD2;
      end
      S_NB_RD2: begin
        if ((ew_rd_r == '0) || closed_r[v_r[AW-1:0]]) begin
          if (vp1 == nc) begin
            state_nxt = S_SEL_INIT;
          end else begin
            v_nxt     = vp1;
            state_nxt = S_NB_RD1;
          end
        end else begin
          ew_raddr   = {curr_r, v_r[AW-1:0]};
          cost_raddr = v_r[AW-1:0];
          state_nxt  = S_NB_CALC;
        end
      end
      S_NB_CALC: begin
        if (cand < cost_rd_r) begin
          cost_we    = 1'b1;
          cost_wdata = cand;
          came_we    = 1'b1;
          came_wdata = curr_r;
          cand_nxt   = cand;
          xy_raddr   = v_r[AW-1:0];
          state_nxt  = S_NB_H;
        end else begin
          state_nxt = S_NB_OPEN;
        end
      end
      S_NB_H: begin
        hreq.go   = 1'b1;
        hreq.ax   = astar_pkg::abs_diff(xs_rd_r, gx_r);
        hreq.ay   = astar_pkg::abs_diff(ys_rd_r, gy_r);
        state_nxt = S_NB_HW;
      end
      S_NB_HW: begin
        if (hrsp.done) begin
          est_we    = 1'b1;
          est_wdata = astar_pkg::sat_add(cand_r, hrsp.value);
          state_nxt = S_NB_OPEN;
        end
      end
      S_NB_OPEN: begin
        if (!inopen_r[v_r[AW-1:0]]) begin
          open_we    = 1'b1;
          open_waddr = osize_r[AW-1:0];
          open_wdata = v_r[AW-1:0];
          osize_nxt  = osize_r + CW'(1);
          inopen_nxt[v_r[AW-1:0]] = 1'b1;
        end
        if (vp1 == nc) begin
          state_nxt = S_SEL_INIT;
        end else begin
          v_nxt     = vp1;
          state_nxt = S_NB_RD1;
        end
      end
      S_PW_RD: begin
        state_nxt = S_PW_CHK;
      end
      S_PW_CHK: begin
        if ((came_rd_r != pc_r) && (plen_r < nc)) begin
          pbuf_we   = 1'b1;
          plen_nxt  = plen_r + CW'(1);
          pc_nxt    = came_rd_r;
          state_nxt = S_PW_RD;
        end else begin
          if (plen_r < nc) begin
            pbuf_we  = 1'b1;
            plen_nxt = plen_r + CW'(1);
          end
          cnt_nxt   = '0;
          state_nxt = S_EM_RD1;
        end
      end
      S_EM_RD1: begin
        state_nxt = S_EM_RD2;
      end
      S_EM_RD2: begin
        out_vertex_nxt = 6'(pbuf_rd_r);
        xy_raddr       = pbuf_rd_r;
        state_nxt      = S_EM_LOAD;
      end
      S_EM_LOAD: begin
        out_x_nxt     = xs_rd_r;
        out_y_nxt     = ys_rd_r;
        out_found_nxt = 1'b1;
        out_last_nxt  = ((cnt_r + CW'(1)) == plen_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_EM_RD1;
          end
        end
      end
      S_NOTFOUND: begin
        out_vertex_nxt = '0;
        out_x_nxt      = '0;
        out_y_nxt      = '0;
        out_found_nxt  = 1'b0;
        out_last_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_EM_WAIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (xy_we) begin
      xs_mem[xy_waddr] <= x_wdata;
      ys_mem[xy_waddr] <= y_wdata;
    end
    xs_rd_r <= xs_mem[xy_raddr];
    ys_rd_r <= ys_mem[xy_raddr];
    if (ew_we) begin
      ew_mem[ew_waddr] <= ew_wdata;
    end
    ew_rd_r <= ew_mem[ew_raddr];
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rd_r <= cost_mem[cost_raddr];
    if (est_we) begin
      est_mem[est_waddr] <= est_wdata;
    end
    est_rd_r <= est_mem[est_raddr];
    if (came_we) begin
      came_mem[came_waddr] <= came_wdata;
    end
    came_rd_r <= came_mem[came_raddr];
    if (open_we) begin
      open_mem[open_waddr] <= open_wdata;
    end
    open_rd_r <= open_mem[open_raddr];
    if (pbuf_we) begin
      pbuf_mem[pbuf_waddr] <= pbuf_wdata;
    end
    pbuf_rd_r <= pbuf_mem[pbuf_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 7'd64;
      out_valid_r <= 1'b0;
      osize_r     <= '0;
      closed_r    <= '0;
      inopen_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
      osize_r     <= osize_nxt;
      closed_r    <= closed_nxt;
      inopen_r    <= inopen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_vertex_r <= out_vertex_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_found_r  <= out_found_nxt;
    out_last_r   <= out_last_nxt;
    start_r      <= start_nxt;
    goal_r       <= goal_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    v_r          <= v_nxt;
    plen_r       <= plen_nxt;
    cnt_r        <= cnt_nxt;
    best_r       <= best_nxt;
    ccost_r      <= ccost_nxt;
    cand_r       <= cand_nxt;
    curr_r       <= curr_nxt;
    ent_r        <= ent_nxt;
    pc_r         <= pc_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_path_vertex = out_vertex_r;
  assign out_path_x      = out_x_r;
  assign out_path_y      = out_y_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

  `ASTAR_ASSERT_IMP(a_ready_no_out, in_ready, !out_valid, "input ready while result pending")
  `ASTAR_ASSERT_IMP(a_open_bound, 1'b1, osize_r <= CW'(DEPTH), "open list overflow")
  `ASTAR_ASSERT_IMP(a_hdone_wait, hrsp.done, (state_r == S_START_HW) || (state_r == S_NB_HW), "heuristic done unexpected")
  `ASTAR_ASSERT_NXT(a_load_one_cycle, in_valid && in_ready && (in_cmd != astar_pkg::CMD_SEARCH), in_ready, "load item held the block")

endmodule

[tb/sv/a_star_path_checker.sv]
// Path predictor and result comparator for the A* search block.
`timescale 1ns / 1ps
module a_star_path_checker
  import astar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_vertex_index,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [5:0]  in_edge_from,
  input  logic [5:0]  in_edge_to,
  input  logic [15:0] in_edge_weight,
  input  logic [5:0]  in_start_vertex,
  input  logic [5:0]  in_goal_vertex,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_path_vertex,
  input  logic [15:0] out_path_x,
  input  logic [15:0] out_path_y,
  input  logic        out_found,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [5:0]  vertex;
    logic [15:0] x;
    logic [15:0] y;
    logic        found;
    logic        last;
  } path_step_t;

  logic [15:0] pos_x [64];
  logic [15:0] pos_y [64];
  logic [15:0] weight [64][64];
  int unsigned vertex_limit;
  path_step_t  path_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
    vertex_limit = 64;
  end

  function automatic int unsigned live_count();
    return (vertex_limit > 64) ? 64 : vertex_limit;
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] val);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val = val - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] dist_est(input int a, input int b);
    int dx;
    int dy;
    logic [63:0] ax;
    logic [63:0] ay;
    dx = int'($signed(pos_x[a])) - int'($signed(pos_x[b]));
    dy = int'($signed(pos_y[a])) - int'($signed(pos_y[b]));
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    return root64((ax * ax + ay * ay) << 16);
  endfunction

  function automatic logic [31:0] cost_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? COST_INF : s[31:0];
  endfunction

  function automatic void add_step(input int v, input bit fnd, input bit lst);
    path_step_t s;
    s.vertex = v[5:0];
    s.x = fnd ? pos_x[v] : 16'd0;
    s.y = fnd ? pos_y[v] : 16'd0;
    s.found = fnd;
    s.last = lst;
    path_q.push_back(s);
  endfunction

  function automatic void plan_path(input int start, input int goal);
    logic [31:0] g_cost [64];
    logic [31:0] f_cost [64];
    logic [31:0] best;
    logic [31:0] cand;
    int came [64];
    int open_list [64];
    int trail [64];
    bit closed [64];
    int open_n;
    int n;
    int pos;
    int curr;
    int len;
    int c;
    bit listed;
    n = live_count();
    open_n = 0;
    foreach (closed[i]) closed[i] = 0;
    if (start >= n || goal >= n) begin
      add_step(0, 0, 1);
      return;
    end
    for (int v = 0; v < n; v++) begin
      g_cost[v] = COST_INF;
      f_cost[v] = COST_INF;
      came[v] = v;
    end
    g_cost[start] = 0;
    f_cost[start] = dist_est(start, goal);
    open_list[open_n++] = start;
    while (open_n != 0) begin
      pos = 0;
      curr = open_list[0];
      best = f_cost[curr];
      for (int k = 0; k < open_n; k++) begin
        if (f_cost[open_list[k]] <= best) begin
          best = f_cost[open_list[k]];
          curr = open_list[k];
          pos = k;
        end
      end
      for (int k = pos; k + 1 < open_n; k++) open_list[k] = open_list[k + 1];
      open_n--;
      closed[curr] = 1;
      if (curr == goal) begin
        len = 0;
        c = curr;
        while (came[c] != c && len < n) begin
          trail[len++] = c;
          c = came[c] % n;
        end
        if (len < n) trail[len++] = c;
        for (int k = 0; k < len; k++) add_step(trail[len - 1 - k], 1, k + 1 == len);
        return;
      end
      for (int v = 0; v < n; v++) begin
        if (weight[v][curr] == 0) continue;
        if (closed[v]) continue;
        cand = cost_sum(g_cost[curr], {8'd0, weight[curr][v], 8'd0});
        if (cand < g_cost[v]) begin
          g_cost[v] = cand;
          f_cost[v] = cost_sum(cand, dist_est(goal, v));
          came[v] = curr;
        end
        listed = 0;
        for (int k = 0; k < open_n; k++) if (open_list[k] == v) listed = 1;
        if (!listed && open_n < 64) open_list[open_n++] = v;
      end
    end
    add_step(0, 0, 1);
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    path_step_t s;
    if (!rst_n) begin
      vertex_limit = 64;
      path_q.delete();
    end else begin
      if (cfg_wr_en) vertex_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (path_q.size() == 0) begin
          $display("unexpected result item vertex %0d at %0t", out_path_vertex, $realtime);
          fail_count++;
        end else begin
          s = path_q.pop_front();
          if (out_path_vertex !== s.vertex) report("path_vertex", s.vertex, out_path_vertex);
          if (out_path_x !== s.x) report("path_x", s.x, out_path_x);
          if (out_path_y !== s.y) report("path_y", s.y, out_path_y);
          if (out_found !== s.found) report("found", s.found, out_found);
          if (out_last !== s.last) report("last", s.last, out_last);
        end
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_VERTEX: begin
            if (in_vertex_index < live_count()) begin
              pos_x[in_vertex_index] = in_coord_x;
              pos_y[in_vertex_index] = in_coord_y;
            end
          end
          CMD_EDGE: begin
            if (in_edge_from < live_count() && in_edge_to < live_count())
              weight[in_edge_from][in_edge_to] = in_edge_weight;
          end
          CMD_SEARCH: plan_path(in_start_vertex, in_goal_vertex);
          default: ;
        endcase
      end
    end
    pending <= path_q.size();
  end

endmodule

[tb/sv/tb_a_star_shortest_path.sv]
// Stimulus, handshake driving and verdict for the A* search block.
`timescale 1ns / 1ps
module tb_a_star_shortest_path;
  import astar_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [5:0]  in_vertex_index;
  logic [15:0] in_coord_x;
  logic [15:0] in_coord_y;
  logic [5:0]  in_edge_from;
  logic [5:0]  in_edge_to;
  logic [15:0] in_edge_weight;
  logic [5:0]  in_start_vertex;
  logic [5:0]  in_goal_vertex;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_path_vertex;
  logic [15:0] out_path_x;
  logic [15:0] out_path_y;
  logic        out_found;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          in_idle;
  int          out_stall;
  int          quiet_cycles;

  a_star_shortest_path u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_vertex_index(in_vertex_index), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_edge_from(in_edge_from), .in_edge_to(in_edge_to), .in_edge_weight(in_edge_weight),
    .in_start_vertex(in_start_vertex), .in_goal_vertex(in_goal_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .out_path_vertex(out_path_vertex),
    .out_path_x(out_path_x), .out_path_y(out_path_y), .out_found(out_found),
    .out_last(out_last)
  );

  a_star_path_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_vertex_index(in_vertex_index), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_edge_from(in_edge_from), .in_edge_to(in_edge_to), .in_edge_weight(in_edge_weight),
    .in_start_vertex(in_start_vertex), .in_goal_vertex(in_goal_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .out_path_vertex(out_path_vertex),
    .out_path_x(out_path_x), .out_path_y(out_path_y), .out_found(out_found),
    .out_last(out_last), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= out_stall);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin in_idle = 0; out_stall = 0; end
      1: begin in_idle = 54; out_stall = 0; end
      2: begin in_idle = 0; out_stall = 54; end
      default: begin in_idle = 27; out_stall = 27; end
    endcase
  endtask

  task automatic push_item(input logic [1:0] cmd, input logic [5:0] vi,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [5:0] ef, input logic [5:0] et,
                           input logic [15:0] w, input logic [5:0] sv,
                           input logic [5:0] gv);
    bit took;
    while ($urandom_range(0, 99) < in_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_vertex_index = vi;
    in_coord_x = x;
    in_coord_y = y;
    in_edge_from = ef;
    in_edge_to = et;
    in_edge_weight = w;
    in_start_vertex = sv;
    in_goal_vertex = gv;
    forever begin
      #5 took = in_ready;
      @(negedge clk);
      if (took) break;
    end
  endtask

  task automatic put_vertex(input int vi, input logic [15:0] x, input logic [15:0] y);
    push_item(CMD_VERTEX, vi, x, y, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic put_edge(input int f, input int t, input logic [15:0] w);
    push_item(CMD_EDGE, $urandom, $urandom, $urandom, f, t, w, $urandom, $urandom);
  endtask

  task automatic put_search(input int s, input int g);
    push_item(CMD_SEARCH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, s, g);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_count(input logic [6:0] val);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wr_data = $urandom;
  endtask

  function automatic logic [15:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'd0;
    if (r < 45) return 16'hFFFF;
    if (r < 55) return 16'd1;
    if (r < 90) return $urandom_range(1, 300);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(0, 128) - 64;
  endfunction

  task automatic run_phase(input int cnt, input int items, input int m, input bit hold);
    int lim;
    int r;
    write_count(cnt);
    set_mode(m);
    lim = (cnt == 0) ? 64 : ((cnt > 64) ? 64 : cnt);
    for (int i = 0; i < items; i++) begin
      if (hold && i == items / 2) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        put_vertex(($urandom_range(0, 9) != 0) ? $urandom_range(0, lim - 1) : $urandom,
                   pick_coord(), pick_coord());
      end else if (r < 65) begin
        put_edge(($urandom_range(0, 9) != 0) ? $urandom_range(0, lim - 1) : $urandom,
                 $urandom_range(0, lim - 1), pick_weight());
      end else if (r < 95) begin
        put_search($urandom_range(0, lim - 1),
                   ($urandom_range(0, 9) != 0) ? $urandom_range(0, lim - 1) : $urandom);
      end else begin
        push_item(CMD_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_vertex_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_edge_from = '0;
    in_edge_to = '0;
    in_edge_weight = '0;
    in_start_vertex = '0;
    in_goal_vertex = '0;
    out_ready = 1'b0;
    quiet_cycles = 0;
    set_mode(0);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    write_count(7'd64);
    put_vertex(0, 16'h8000, 16'h8000);
    put_vertex(1, 16'h7FFF, 16'h7FFF);
    for (int v = 2; v < 64; v++) put_vertex(v, pick_coord(), pick_coord());
    for (int f = 0; f < 64; f++) begin
      for (int t = 0; t < 64; t++) begin
        if ((f == 0 && t == 1) || (f == 1 && t == 0)) put_edge(f, t, 16'hFFFF);
        else put_edge(f, t, ($urandom_range(0, 99) < 92) ? 16'd0 : pick_weight());
      end
    end
    put_search(0, 1);
    put_search(5, 5);
    put_search(0, 63);
    put_search(63, 0);
    push_item(CMD_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);

    write_count(7'd4);
    put_edge(0, 1, 16'd2);
    put_edge(1, 0, 16'd2);
    put_edge(1, 2, 16'd0);
    put_edge(2, 1, 16'd3);
    put_edge(0, 2, 16'd5);
    put_edge(2, 0, 16'd5);
    put_search(0, 2);
    put_search(0, 3);
    put_search(3, 3);
    put_search(4, 0);

    run_phase(2, 50, 0, 0);
    run_phase(8, 50, 1, 1);
    run_phase(5, 50, 2, 0);
    run_phase(3, 50, 3, 0);
    run_phase(1, 20, 0, 0);
    run_phase(0, 15, 1, 0);
    run_phase(127, 12, 2, 0);
    run_phase(10, 50, 3, 0);
    run_phase(64, 8, 0, 0);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
